// ===== rtl/prime_generator_trial_division_macros.svh =====
// ---------------------------------------------------------------------------
// Prime generator assertion macros
// Shared property wrappers for clocked checks with synchronous reset.
// ---------------------------------------------------------------------------
`ifndef PRIME_GENERATOR_TRIAL_DIVISION_MACROS_SVH
`define PRIME_GENERATOR_TRIAL_DIVISION_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define PTD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is low
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/ptd_pkg.sv =====
// ---------------------------------------------------------------------------
// ptd_pkg
// Shared constants and types of the trial-division prime generator.
// ---------------------------------------------------------------------------
package ptd_pkg;

  // Default sizes
  localparam int VALUE_BITS_DEF  = 20;
  localparam int TABLE_DEPTH_DEF = 256;

  // Reset value of the upper limit register
  localparam int LIMIT_RESET = 1000000;

  // Fixed points of the candidate sequence
  localparam int CAND_FIRST     = 2;
  localparam int CAND_SECOND    = 3;
  localparam int CAND_ODD_START = 5;
  localparam int CAND_STEP      = 2;

  // Register index (word address bit above the byte lanes)
  localparam logic REG_UPPER_LIMIT = 1'b0;

  // Status of the remainder unit
  typedef struct packed {
    logic done;      // one-cycle pulse: remainder is final
    logic rem_zero;  // remainder is zero, valid with done
  } ptd_mod_status_t;

endpackage

// ===== rtl/ptd_ram.sv =====
// ---------------------------------------------------------------------------
// ptd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module ptd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ptd_mod.sv =====
// ---------------------------------------------------------------------------
// ptd_mod
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ---------------------------------------------------------------------------
module ptd_mod #(
  parameter int DIVIDEND_BITS = 21,
  parameter int DIVISOR_BITS  = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DIVIDEND_BITS-1:0]     dividend,
  input  logic [DIVISOR_BITS-1:0]      divisor,
  output ptd_pkg::ptd_mod_status_t     status
);
  import ptd_pkg::*;

  localparam int CNTW = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] shift_r, shift_nxt;
  logic [DIVISOR_BITS-1:0]  div_r, div_nxt;
  logic [DIVISOR_BITS-1:0]  rem_r, rem_nxt;
  logic [CNTW-1:0]          cnt_r, cnt_nxt;
  logic                     done_r, done_nxt;
  logic [DIVISOR_BITS:0]    trial;

  // Load on start; otherwise shift in the next dividend bit and subtract when it fits
  always_comb begin
    shift_nxt = shift_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    trial     = {rem_r, shift_r[DIVIDEND_BITS-1]};
    if (start) begin
      shift_nxt = dividend;
      div_nxt   = divisor;
      rem_nxt   = '0;
      cnt_nxt   = CNTW'(DIVIDEND_BITS);
    end else if (cnt_r != '0) begin
      shift_nxt = {shift_r[DIVIDEND_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_nxt  = trial[DIVISOR_BITS-1:0];
      cnt_nxt  = cnt_r - CNTW'(1);
      done_nxt = (cnt_r == CNTW'(1));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
  end

  assign status.done     = done_r;
  assign status.rem_zero = (rem_r == '0);

endmodule

// ===== rtl/prime_generator_trial_division.sv =====
// ---------------------------------------------------------------------------
// prime_generator_trial_division
// Returns the next prime up to a configured limit on each request.
// ---------------------------------------------------------------------------
// Pulse start while busy is low; in_restart high restarts the sequence at 2.
// Exactly one result comes back per request as a single-cycle out_valid
// strobe that cannot be held off, so capture it when it appears; out_done_res
// set (with out_prime_value zero) says no prime is left at or below the
// limit. The odd primes found that fit a table entry are kept in a RAM table,
// while room is left, and each candidate is divided by them in turn while
// the divisor squared does not exceed it. Each divisor takes a table read,
// a squaring, a compare and a bit-serial remainder of VALUE_BITS+1 steps;
// the read whose square exceeds the candidate ends the search, as does the
// end of the table, and the prime is then reported. The table needs no
// clearing after reset. Change upper_limit only while the block is idle.
// ---------------------------------------------------------------------------
`include "prime_generator_trial_division_macros.svh"

module prime_generator_trial_division #(
  parameter int VALUE_BITS  = ptd_pkg::VALUE_BITS_DEF,
  parameter int TABLE_DEPTH = ptd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_restart,
  // Result channel
  output logic                  out_valid,
  output logic [VALUE_BITS-1:0] out_prime_value,
  output logic                  out_done_res,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import ptd_pkg::*;

  localparam int CW   = VALUE_BITS + 1;            // candidate width
  localparam int EB   = (VALUE_BITS + 1) / 2;      // table entry width
  localparam int IW   = $clog2(TABLE_DEPTH);       // table index width
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);   // table count width
  localparam int SQW  = 2 * EB;
  localparam int CMPW = (CW > SQW) ? CW : SQW;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CAND  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_SQ    = 7'b0001000,
    ST_CMP   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_FOUND = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] limit_r;
  logic [CNTW-1:0]       count_r, count_nxt;
  logic [CNTW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]         cand_r, cand_nxt;
  logic                  finished_r, finished_nxt;
  logic [EB-1:0]         div_r, div_nxt;
  logic [SQW-1:0]        sq_r, sq_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic                  out_done_r, out_done_nxt;

  logic                  cfg_wr;
  logic                  accept;
  logic                  ram_we;
  logic                  ram_re;
  logic [EB-1:0]         ram_rdata;
  logic                  mod_start;
  ptd_mod_status_t       mod_st;
  logic [CW-1:0]         cand_adv;
  logic [CNTW-1:0]       idx_inc;
  logic                  bound_hit;
  logic                  fits_table;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_UPPER_LIMIT);
  assign prdata = (paddr[2] == REG_UPPER_LIMIT) ? 32'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= VALUE_BITS'(LIMIT_RESET);
    end else if (cfg_wr) begin
      limit_r <= pwdata[VALUE_BITS-1:0];
    end
  end

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Next candidate: 2 -> 3 -> 5 -> odd steps
  always_comb begin
    if (cand_r < CW'(CAND_SECOND)) begin
      cand_adv = CW'(CAND_SECOND);
    end else if (cand_r == CW'(CAND_SECOND)) begin
      cand_adv = CW'(CAND_ODD_START);
    end else begin
      cand_adv = cand_r + CW'(CAND_STEP);
    end
  end

  assign idx_inc    = idx_r + CNTW'(1);
  assign bound_hit  = CMPW'(sq_r) > CMPW'(cand_r);
  assign fits_table = (cand_r >= CW'(CAND_SECOND)) && ((cand_r >> EB) == '0)
                      && (count_r < CNTW'(TABLE_DEPTH));
  assign ram_we     = (state_r == ST_FOUND) && fits_table;
  assign ram_re     = (state_r == ST_RD);
  assign mod_start  = (state_r == ST_CMP) && !bound_hit;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cand_nxt      = cand_r;
    finished_nxt  = finished_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_done_nxt  = out_done_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_restart) begin
            count_nxt    = '0;
            cand_nxt     = CW'(CAND_FIRST);
            finished_nxt = 1'b0;
          end
          state_nxt = ST_CAND;
        end
      end
      ST_CAND: begin
        // Drop out as done, take small candidates directly, else start division
        if (finished_r || (cand_r > {1'b0, limit_r})) begin
          finished_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_done_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else if ((cand_r <= CW'(CAND_SECOND)) || (count_r == '0)) begin
          state_nxt = ST_FOUND;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        // Hold the divisor and register its square
        div_nxt   = ram_rdata;
        sq_nxt    = SQW'(ram_rdata) * SQW'(ram_rdata);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = bound_hit ? ST_FOUND : ST_DIV;
      end
      ST_DIV: begin
        if (mod_st.done) begin
          if (mod_st.rem_zero) begin
            cand_nxt  = cand_adv;
            state_nxt = ST_CAND;
          end else if (idx_inc == count_r) begin
            state_nxt = ST_FOUND;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = ST_RD;
          end
        end
      end
      ST_FOUND: begin
        // Store the prime if it fits, report it and advance
        if (fits_table) begin
          count_nxt = count_r + CNTW'(1);
        end
        cand_nxt      = cand_adv;
        out_valid_nxt = 1'b1;
        out_value_nxt = cand_r[VALUE_BITS-1:0];
        out_done_nxt  = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cand_r      <= CW'(CAND_FIRST);
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cand_r      <= cand_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    div_r       <= div_nxt;
    sq_r        <= sq_nxt;
    out_value_r <= out_value_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_prime_value = out_value_r;
  assign out_done_res    = out_done_r;

  // Prime table
  ptd_ram #(
    .WIDTH (EB),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IW-1:0]),
    .wdata (cand_r[EB-1:0]),
    .re    (ram_re),
    .raddr (idx_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  // Remainder unit
  ptd_mod #(
    .DIVIDEND_BITS (CW),
    .DIVISOR_BITS  (EB)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (cand_r),
    .divisor  (div_r),
    .status   (mod_st)
  );

  // Checks
  `PTD_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  `PTD_ASSERT_SAME(a_done_zero, clk, rst_n, out_valid_r && out_done_r, out_value_r == '0)
  `PTD_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNTW'(TABLE_DEPTH))
  `PTD_ASSERT_SAME(a_mod_owner, clk, rst_n, mod_st.done, state_r == ST_DIV)

endmodule

// ===== tb/sv/prime_generator_trial_division_test.sv =====
// ---------------------------------------------------------------------------
// prime_generator_trial_division_test
// Drives prime requests and limit writes into the trial-division prime
// generator and compares every result strobe against a cycle-free predictor
// of the prime sequence kept in a small scoreboard class.
// ---------------------------------------------------------------------------
module prime_generator_trial_division_test;
  import ptd_pkg::*;

  localparam int VB          = VALUE_BITS_DEF;
  localparam int CW          = VB + 1;
  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int ENTRY_BITS  = (VB + 1) / 2;
  localparam int ITEM_TARGET = 600;
  localparam int PRINT_CAP   = 40;
  localparam logic [2:0] LIMIT_ADDR = {REG_UPPER_LIMIT, 2'b00};

  typedef struct {
    logic [VB-1:0] prime_value;
    logic          done_res;
  } prime_result_t;

  // Predict the prime sequence and hold the results still to come
  class prime_scoreboard;
    logic [ENTRY_BITS-1:0] odd_primes [DEPTH];
    int unsigned           prime_count;
    logic [VB:0]           next_candidate;
    bit                    exhausted;
    logic [VB-1:0]         upper_limit;
    prime_result_t         expected_primes [$];
    int unsigned           errors;

    function new();
      prime_count    = 0;
      next_candidate = CW'(CAND_FIRST);
      exhausted      = 1'b0;
      upper_limit    = VB'(LIMIT_RESET);
      errors         = 0;
    endfunction

    function void set_limit(logic [31:0] value);
      upper_limit = value[VB-1:0];
    endfunction

    // Divide by the stored odd primes while the divisor squared fits
    function bit passes_trial(longint unsigned c);
      longint unsigned d;
      for (int unsigned i = 0; i < prime_count && i < DEPTH; i++) begin
        d = 64'(odd_primes[i]);
        if (d == 0 || d * d > c) return 1'b1;
        if (c % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Note one accepted request and queue the prime (or done) it yields
    function void accept_request(bit restart);
      longint unsigned c;
      bit              is_prime;
      prime_result_t   r;
      if (restart) begin
        prime_count    = 0;
        next_candidate = CW'(CAND_FIRST);
        exhausted      = 1'b0;
      end
      r.prime_value = '0;
      r.done_res    = 1'b1;
      while (!exhausted && next_candidate <= {1'b0, upper_limit}) begin
        c        = 64'(next_candidate);
        is_prime = (c <= CAND_SECOND) ? 1'b1 : passes_trial(c);
        if (c < CAND_SECOND) begin
          next_candidate = CW'(CAND_SECOND);
        end else if (c == CAND_SECOND) begin
          next_candidate = CW'(CAND_ODD_START);
        end else begin
          next_candidate = next_candidate + CW'(CAND_STEP);
        end
        if (is_prime) begin
          // keep odd primes that fit an entry, while room is left
          if (c >= CAND_SECOND && c < (64'd1 << ENTRY_BITS) && prime_count < DEPTH) begin
            odd_primes[prime_count] = c[ENTRY_BITS-1:0];
            prime_count++;
          end
          r.prime_value = c[VB-1:0];
          r.done_res    = 1'b0;
          break;
        end
      end
      if (r.done_res) exhausted = 1'b1;
      expected_primes.push_back(r);
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one result transfer with the oldest expectation
    task check_result(logic [VB-1:0] value, logic done);
      prime_result_t e;
      if (expected_primes.size() == 0) begin
        report($sformatf("unexpected result prime_value=%0d done_res=%0b", value, done));
        return;
      end
      e = expected_primes.pop_front();
      if (value !== e.prime_value)
        report($sformatf("prime_value %0d, expected %0d", value, e.prime_value));
      if (done !== e.done_res)
        report($sformatf("done_res %0b, expected %0b", done, e.done_res));
    endtask
  endclass

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          start      = 1'b0;
  logic          in_restart = 1'b0;
  logic          psel       = 1'b0;
  logic          penable    = 1'b0;
  logic          pwrite     = 1'b0;
  logic [2:0]    paddr      = '0;
  logic [31:0]   pwdata     = '0;
  logic          busy;
  logic          out_valid;
  logic [VB-1:0] out_prime_value;
  logic          out_done_res;
  logic [31:0]   prdata;
  logic          pready;

  prime_scoreboard sb = new();
  int unsigned     items_sent = 0;

  always #5 clk = ~clk;

  prime_generator_trial_division dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_prime_value (out_prime_value),
    .out_done_res    (out_done_res),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Capture each result transfer at the edge that ends its strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_prime_value, out_done_res);
  end

  // Hold start until the request transfer completes; start stays high
  task automatic request_prime(bit restart);
    start      <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (busy);
    sb.accept_request(restart);
    items_sent++;
  endtask

  // Drop start and idle, with noise on the restart line
  task automatic pause(int unsigned cycles);
    start      <= 1'b0;
    in_restart <= 1'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    pause(0);
    @(posedge clk);
    while (sb.expected_primes.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the limit register, then read it back
  task automatic write_limit(logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_limit(value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== {{(32 - VB){1'b0}}, sb.upper_limit})
      sb.report($sformatf("upper_limit reads %0d, expected %0d", readback, sb.upper_limit));
  endtask

  initial begin
    logic [31:0]  wr_value;
    logic [VB-1:0] limit_value;
    bit           long_phase;
    bit           first_restart;
    int unsigned  phase_items;
    int unsigned  done_items;
    int unsigned  burst;
    int unsigned  pick;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first primes at the reset limit, then restart
    request_prime(1'b0);
    request_prime(1'b0);
    request_prime(1'b0);
    request_prime(1'b1);
    request_prime(1'b0);

    // Limit zero: done at once, and done stays
    wait_drained();
    write_limit(32'd0);
    request_prime(1'b0);
    request_prime(1'b0);

    // Limit one with restart: still done
    wait_drained();
    write_limit(32'd1);
    request_prime(1'b1);

    // Limit two and three: smallest sequences
    wait_drained();
    write_limit(32'd2);
    request_prime(1'b1);
    request_prime(1'b0);
    wait_drained();
    write_limit(32'd3);
    request_prime(1'b1);
    request_prime(1'b0);
    request_prime(1'b0);

    // Largest limit: done stays sticky until restart
    wait_drained();
    write_limit((32'd1 << VB) - 1);
    request_prime(1'b0);
    request_prime(1'b1);
    request_prime(1'b0);
    request_prime(1'b0);
    request_prime(1'b0);

    // Lower the limit mid-sequence; upper data bits are ignored
    wait_drained();
    write_limit(32'hFFF0_0000 | 32'd10);
    request_prime(1'b0);
    request_prime(1'b1);

    // Raise it mid-sequence, then lower it below the candidate
    wait_drained();
    write_limit(32'd30);
    request_prime(1'b0);
    request_prime(1'b0);
    wait_drained();
    write_limit(32'd4);
    request_prime(1'b0);

    // Random phases: new limit, then bursts of requests
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      long_phase = ($urandom_range(0, 9) == 0);
      pick       = $urandom_range(0, 15);
      if (long_phase) begin
        limit_value = VB'($urandom_range(20000, (1 << VB) - 1));
      end else if (pick == 0) begin
        limit_value = VB'($urandom_range(0, 3));
      end else if (pick == 1) begin
        limit_value = VB'($urandom());
      end else if (pick <= 11) begin
        limit_value = VB'($urandom_range(2, 700));
      end else begin
        limit_value = VB'($urandom_range(700, 4000));
      end
      wr_value          = $urandom();
      wr_value[VB-1:0]  = limit_value;
      write_limit(wr_value);

      phase_items   = long_phase ? 150 : $urandom_range(5, 60);
      first_restart = ($urandom_range(0, 3) != 0);
      done_items    = 0;
      while (done_items < phase_items) begin
        burst = $urandom_range(1, 12);
        for (int unsigned j = 0; j < burst && done_items < phase_items; j++) begin
          if (done_items == 0) begin
            request_prime(first_restart);
          end else begin
            request_prime(!long_phase && $urandom_range(0, 24) == 0);
          end
          done_items++;
        end
        // Gap after the burst: none, short or long, or a full drain
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
          wait_drained();
        end else if (pick >= 3) begin
          pause($urandom_range(1, 40));
        end
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_primes.size() == 0) begin
      $display("prime_generator_trial_division test passed");
    end else begin
      $display("prime_generator_trial_division test failed");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #200_000_000;
    $display("prime_generator_trial_division test failed");
    $finish;
  end

endmodule
